// ===== sv/stris_pkg.sv =====
// Shared constants, command and state types for the sorted table range search.
package stris_pkg;

  localparam int MAX_POSITIONS = 1048576;
  localparam int MAX_CHROMS    = 1024;

  localparam int ADDR_W     = $clog2(MAX_POSITIONS);
  localparam int IDX_W      = ADDR_W + 1;
  localparam int CID_W      = $clog2(MAX_CHROMS);
  localparam int CNT_W      = CID_W + 1;
  localparam int VAL_W      = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = IDX_W;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [MODE_W-1:0] MODE_LOAD_POS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHROM_COUNT = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [VAL_W-1:0]  key_start;
    logic [VAL_W-1:0]  key_stop;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    F_IDLE,
    F_QUERY
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SEARCH,
    B_DONE
  } back_state_t;

endpackage

// ===== sv/stris_queue.sv =====
// Short command queue between the front and back sections.
module stris_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  stris_pkg::cmd_t     push_cmd,
  input  logic                pop,
  output stris_pkg::cmd_t     pop_cmd,
  output stris_pkg::q_status_t status
);
  import stris_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  assign pop_cmd      = slots[rd_ptr];
  assign status.full  = (count == (QPTR_W + 1)'(QDEPTH));
  assign status.empty = (count == '0);

endmodule

// ===== sv/stris_front.sv =====
// Front section: config registers, start offset table, request classification.
module stris_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [stris_pkg::MODE_W-1:0]        mode,
  input  logic [stris_pkg::ADDR_W-1:0]        entry_address,
  input  logic [stris_pkg::VAL_W-1:0]         entry_value,
  input  logic [stris_pkg::CID_W-1:0]         chrom_id,
  input  logic [stris_pkg::VAL_W-1:0]         range_start,
  input  logic [stris_pkg::VAL_W-1:0]         range_stop,
  input  logic                                cfg_write,
  input  logic [stris_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stris_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  stris_pkg::q_status_t                q_status,
  output logic                                push,
  output stris_pkg::cmd_t                     push_cmd
);
  import stris_pkg::*;

  localparam logic [IDX_W-1:0] POS_LIMIT = IDX_W'(MAX_POSITIONS);

  front_state_t      state;
  front_state_t      state_next;

  logic [IDX_W-1:0]  total_positions;
  logic [CNT_W-1:0]  chrom_count;

  logic [IDX_W-1:0]  start_mem [MAX_CHROMS];
  logic [IDX_W-1:0]  lo_rd;
  logic [IDX_W-1:0]  hi_rd;
  logic              use_next;
  logic [VAL_W-1:0]  key_start;
  logic [VAL_W-1:0]  key_stop;

  logic              accept;
  logic              is_bad;
  logic [CNT_W-1:0]  cid_plus;
  logic              has_next;
  logic [CID_W-1:0]  next_cid;
  logic [IDX_W-1:0]  hi_raw;
  logic [IDX_W-1:0]  hi_fix;
  logic [IDX_W-1:0]  lo_lim;
  logic [IDX_W-1:0]  hi_lim;

  assign accept   = in_valid && in_ready;
  assign is_bad   = CNT_W'(chrom_id) >= chrom_count;
  assign cid_plus = CNT_W'(chrom_id) + CNT_W'(1);
  assign has_next = (cid_plus < chrom_count) && (cid_plus < CNT_W'(MAX_CHROMS));
  assign next_cid = chrom_id + CID_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_positions <= '0;
      chrom_count     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TOTAL:       total_positions <= cfg_data;
        REG_CHROM_COUNT: chrom_count     <= cfg_data[CNT_W-1:0];
        default:         ;
      endcase
    end
  end

  // start table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_LOAD_START && entry_address < ADDR_W'(MAX_CHROMS)) begin
      start_mem[entry_address[CID_W-1:0]] <= entry_value[IDX_W-1:0];
    end
    if (accept && mode == MODE_QUERY) begin
      lo_rd     <= start_mem[chrom_id];
      hi_rd     <= start_mem[next_cid];
      use_next  <= has_next;
      key_start <= range_start;
      key_stop  <= range_stop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept && mode == MODE_QUERY && !is_bad) begin
          state_next = F_QUERY;
        end
      end
      F_QUERY: begin
        if (!q_status.full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // slice bounds: empty when end is below start, both limited to the table
  always_comb begin
    hi_raw = use_next ? hi_rd : total_positions;
    hi_fix = (hi_raw < lo_rd) ? lo_rd : hi_raw;
    lo_lim = (lo_rd > POS_LIMIT) ? POS_LIMIT : lo_rd;
    hi_lim = (hi_fix > POS_LIMIT) ? POS_LIMIT : hi_fix;
  end

  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    push_cmd = '0;
    case (state)
      F_IDLE: begin
        in_ready       = !q_status.full;
        push           = accept && (mode == MODE_LOAD_POS || (mode == MODE_QUERY && is_bad));
        push_cmd.kind  = (mode == MODE_LOAD_POS) ? CMD_LOAD : CMD_BAD;
        push_cmd.addr  = entry_address;
        push_cmd.value = entry_value;
      end
      F_QUERY: begin
        push               = !q_status.full;
        push_cmd.kind      = CMD_QUERY;
        push_cmd.lo        = lo_lim;
        push_cmd.hi        = hi_lim;
        push_cmd.key_start = key_start;
        push_cmd.key_stop  = key_stop;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/stris_back.sv =====
// Back section: position table, two lower-bound searches, result register.
module stris_back (
  input  logic                         clk,
  input  logic                         rst,
  input  stris_pkg::q_status_t         q_status,
  input  stris_pkg::cmd_t              pop_cmd,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stris_pkg::IDX_W-1:0]  first_index,
  output logic [stris_pkg::IDX_W-1:0]  end_index,
  output logic                         bad_chrom
);
  import stris_pkg::*;

  back_state_t       state;
  back_state_t       state_next;

  logic [VAL_W-1:0]  pos_mem [MAX_POSITIONS];
  logic [VAL_W-1:0]  rd_data;

  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  count;
  logic [IDX_W-1:0]  probe;
  logic [IDX_W-1:0]  hi;
  logic [VAL_W-1:0]  key;
  logic [VAL_W-1:0]  key_stop;
  logic              phase;
  logic              pending;
  logic [IDX_W-1:0]  first_res;

  logic [IDX_W-1:0]  step;
  logic              below;
  logic [IDX_W-1:0]  lo_b;
  logic [IDX_W-1:0]  cnt_b;
  logic [IDX_W-1:0]  addr_b;
  logic [IDX_W-1:0]  addr_a;
  logic [IDX_W-1:0]  lo_n;
  logic [IDX_W-1:0]  cnt_n;
  logic [IDX_W-1:0]  addr_n;
  logic              done_n;
  logic              slot_free;
  logic              mem_we;
  logic              mem_re;
  logic              res_load;

  // both outcomes of the pending probe are formed alongside the compare
  always_comb begin
    step   = count >> 1;
    below  = rd_data < key;
    lo_b   = probe + IDX_W'(1);
    cnt_b  = count - step - IDX_W'(1);
    addr_b = lo_b + (cnt_b >> 1);
    addr_a = lo + (step >> 1);
    if (!pending) begin
      lo_n   = lo;
      cnt_n  = count;
      addr_n = lo + step;
    end else if (below) begin
      lo_n   = lo_b;
      cnt_n  = cnt_b;
      addr_n = addr_b;
    end else begin
      lo_n   = lo;
      cnt_n  = step;
      addr_n = addr_a;
    end
    done_n = (cnt_n == '0);
  end

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_status.empty && pop_cmd.kind == CMD_QUERY) begin
          state_next = B_SEARCH;
        end
      end
      B_SEARCH: begin
        if (done_n && phase) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (slot_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    res_load = 1'b0;
    case (state)
      B_IDLE: begin
        pop      = !q_status.empty && (pop_cmd.kind != CMD_BAD || slot_free);
        mem_we   = pop && pop_cmd.kind == CMD_LOAD;
        res_load = pop && pop_cmd.kind == CMD_BAD;
      end
      B_SEARCH: mem_re   = !done_n;
      B_DONE:   res_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pos_mem[pop_cmd.addr] <= pop_cmd.value;
    end
    if (mem_re) begin
      rd_data <= pos_mem[addr_n[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop && pop_cmd.kind == CMD_QUERY) begin
      lo       <= pop_cmd.lo;
      count    <= pop_cmd.hi - pop_cmd.lo;
      hi       <= pop_cmd.hi;
      key      <= pop_cmd.key_start;
      key_stop <= pop_cmd.key_stop;
      phase    <= 1'b0;
    end else if (state == B_SEARCH) begin
      lo <= lo_n;
      if (done_n) begin
        if (!phase) begin
          // stop search resumes from the start result
          first_res <= lo_n;
          count     <= hi - lo_n;
          key       <= key_stop;
          phase     <= 1'b1;
        end
      end else begin
        count <= cnt_n;
        probe <= addr_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      first_index <= (state == B_DONE) ? first_res : '0;
      end_index   <= (state == B_DONE) ? lo : '0;
      bad_chrom   <= (state != B_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== sv/sorted_table_range_to_index_search.sv =====
// Top level of the sorted table range search: front, queue and back.
//
//  channel  signals                           direction  moves
//  in       in_valid / in_ready + 6 fields    input      load or query request
//  out      out_valid / out_ready + 3 fields  output     query result
//  cfg      cfg_write, cfg_index, cfg_data    input      register write
//
// A query result follows two lower-bound searches after acceptance, one over the slice of n entries
// and one over the slice part of m entries from first_index on: one probe a cycle into
// the single-port position memory per search.
// A load passes through the front, the queue and the back; an out-of-range sequence
// is answered through the queue and the result register, without a search, when the back is idle.
// Synchronous reset clears control only; both tables are unset until loaded. The front
// keeps accepting while the back searches, until the queue fills.
module sorted_table_range_to_index_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [stris_pkg::MODE_W-1:0]        mode,
  input  logic [stris_pkg::ADDR_W-1:0]        entry_address,
  input  logic [stris_pkg::VAL_W-1:0]         entry_value,
  input  logic [stris_pkg::CID_W-1:0]         chrom_id,
  input  logic [stris_pkg::VAL_W-1:0]         range_start,
  input  logic [stris_pkg::VAL_W-1:0]         range_stop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [stris_pkg::IDX_W-1:0]         first_index,
  output logic [stris_pkg::IDX_W-1:0]         end_index,
  output logic                                bad_chrom,
  input  logic                                cfg_write,
  input  logic [stris_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stris_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import stris_pkg::*;

  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      pop_cmd;
  q_status_t q_status;

  stris_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .entry_address (entry_address),
    .entry_value   (entry_value),
    .chrom_id      (chrom_id),
    .range_start   (range_start),
    .range_stop    (range_stop),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_status      (q_status),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  stris_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  stris_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .pop_cmd     (pop_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .first_index (first_index),
    .end_index   (end_index),
    .bad_chrom   (bad_chrom)
  );

endmodule

// ===== sv/stris_check.sv =====
// Port-level checks on the result channel of the range search, bound to the top.
module stris_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [stris_pkg::IDX_W-1:0]  first_index,
  input logic [stris_pkg::IDX_W-1:0]  end_index,
  input logic                         bad_chrom
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_index) &&
      $stable(end_index) && $stable(bad_chrom))
    else $error("result changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_chrom |-> first_index == '0 && end_index == '0)
    else $error("bad sequence result carries nonzero indices");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_chrom |-> end_index >= first_index)
    else $error("end index below first index");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sorted_table_range_to_index_search stris_check u_check (.*);

// ===== bench/sorted_table_range_to_index_search_tb.sv =====
// Testbench for the sorted table range search: directed table, then checked random phases.
`timescale 1ns / 1ps

module sorted_table_range_to_index_search_tb;
  import stris_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned RAND_ITEMS   = 750;
  localparam int unsigned CALM_AFTER   = 650;
  localparam int unsigned DRAIN_CYCLES = 64;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    logic [CID_W-1:0]  cid;
    logic [VAL_W-1:0]  rstart;
    logic [VAL_W-1:0]  rstop;
  } site_req_t;

  typedef struct {
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] end_index;
    logic             bad_chrom;
  } range_hit_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    site_req_t   req;
    bit          typed;
    range_hit_t  hit;
    int unsigned total;
    int unsigned count;
  } plan_row_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [MODE_W-1:0]     mode          = '0;
  logic [ADDR_W-1:0]     entry_address = '0;
  logic [VAL_W-1:0]      entry_value   = '0;
  logic [CID_W-1:0]      chrom_id      = '0;
  logic [VAL_W-1:0]      range_start   = '0;
  logic [VAL_W-1:0]      range_stop    = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [IDX_W-1:0]      first_index;
  logic [IDX_W-1:0]      end_index;
  logic                  bad_chrom;
  logic                  cfg_write     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // predictor state
  logic [VAL_W-1:0] site_pos [int unsigned];
  logic [IDX_W-1:0] seq_start [int unsigned];
  int unsigned      total_pos = 0;
  int unsigned      seq_count = 0;

  range_hit_t       awaited[$];
  logic [VAL_W-1:0] phase_sites[$];

  int unsigned mismatches = 0;
  int unsigned reqs_sent  = 0;
  int unsigned stall_pct  = 20;
  int unsigned gap_pct    = 25;
  int unsigned hold_left  = 0;
  bit          calm       = 1'b0;

  sorted_table_range_to_index_search u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .entry_address (entry_address),
    .entry_value   (entry_value),
    .chrom_id      (chrom_id),
    .range_start   (range_start),
    .range_stop    (range_stop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .first_index   (first_index),
    .end_index     (end_index),
    .bad_chrom     (bad_chrom),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("sorted_table_range_to_index_search: mismatch");
    $finish;
  end

  // Halving lower bound; ok drops if a probe lands on a never-written entry.
  function automatic int unsigned first_not_below(int unsigned lo, int unsigned hi,
                                                  logic [VAL_W-1:0] key, inout bit ok);
    int unsigned count;
    int unsigned step;
    int unsigned probe;
    count = hi - lo;
    while (count != 0) begin
      step  = count / 2;
      probe = lo + step;
      if (!site_pos.exists(probe)) begin
        ok = 1'b0;
        return lo;
      end
      if (site_pos[probe] < key) begin
        lo    = probe + 1;
        count = count - (step + 1);
      end else begin
        count = step;
      end
    end
    return lo;
  endfunction

  // Returns 0 when answering would read a table entry never written.
  function automatic bit query_result(logic [CID_W-1:0] cid, logic [VAL_W-1:0] rs,
                                      logic [VAL_W-1:0] rp, output range_hit_t res);
    int unsigned c;
    int unsigned lo;
    int unsigned hi;
    int unsigned f;
    int unsigned e;
    bit          ok;
    ok = 1'b1;
    c  = cid;
    res.first_index = '0;
    res.end_index   = '0;
    res.bad_chrom   = 1'b0;
    if (c >= seq_count || c >= MAX_CHROMS) begin
      res.bad_chrom = 1'b1;
      return 1'b1;
    end
    if (!seq_start.exists(c)) return 1'b0;
    lo = seq_start[c];
    if (c + 1 < seq_count && c + 1 < MAX_CHROMS) begin
      if (!seq_start.exists(c + 1)) return 1'b0;
      hi = seq_start[c + 1];
    end else begin
      hi = total_pos;
    end
    if (hi < lo) hi = lo;
    if (lo > MAX_POSITIONS) lo = MAX_POSITIONS;
    if (hi > MAX_POSITIONS) hi = MAX_POSITIONS;
    f = first_not_below(lo, hi, rs, ok);
    e = first_not_below(f, hi, rp, ok);
    res.first_index = IDX_W'(f);
    res.end_index   = IDX_W'(e);
    return ok;
  endfunction

  task automatic track_request(input site_req_t r);
    range_hit_t h;
    case (r.mode)
      MODE_LOAD_POS: site_pos[int'(r.addr)] = r.value;
      MODE_LOAD_START: begin
        if (r.addr < MAX_CHROMS) seq_start[int'(r.addr)] = r.value[IDX_W-1:0];
      end
      MODE_QUERY: begin
        void'(query_result(r.cid, r.rstart, r.rstop, h));
        awaited.insert(awaited.size(), h);
      end
      default: ;
    endcase
  endtask

  // Entered and left at a rising edge; returns at the edge that takes the request.
  task automatic send_req(input site_req_t r);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= r.mode;
    entry_address <= r.addr;
    entry_value   <= r.value;
    chrom_id      <= r.cid;
    range_start   <= r.rstart;
    range_stop    <= r.rstop;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    reqs_sent++;
  endtask

  // Drain: loads give no result, so wait past the last one too.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned total, input int unsigned count);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_TOTAL;
    cfg_data  <= CFG_DATA_W'(total);
    @(posedge clk);
    total_pos = total & 32'h1F_FFFF;
    cfg_index <= REG_CHROM_COUNT;
    cfg_data  <= CFG_DATA_W'(count);
    @(posedge clk);
    seq_count = count & 32'h7FF;
    cfg_write <= 1'b0;
  endtask

  function automatic site_req_t scrambled_req();
    site_req_t r;
    r.mode   = MODE_W'($urandom());
    r.addr   = ADDR_W'($urandom());
    r.value  = $urandom();
    r.cid    = CID_W'($urandom());
    r.rstart = $urandom();
    r.rstop  = $urandom();
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5 && phase_sites.size() != 0)
      return phase_sites[$urandom_range(0, phase_sites.size() - 1)] + $urandom_range(0, 2) - 1;
    if (sel < 8) return $urandom();
    if (sel == 8) return '0;
    return '1;
  endfunction

  function automatic plan_row_t req_row(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
                                        logic [VAL_W-1:0] v, logic [CID_W-1:0] c,
                                        logic [VAL_W-1:0] rs, logic [VAL_W-1:0] rp);
    plan_row_t row;
    row.kind            = ROW_REQ;
    row.req.mode        = m;
    row.req.addr        = a;
    row.req.value       = v;
    row.req.cid         = c;
    row.req.rstart      = rs;
    row.req.rstop       = rp;
    row.typed           = 1'b0;
    row.hit.first_index = '0;
    row.hit.end_index   = '0;
    row.hit.bad_chrom   = 1'b0;
    row.total           = 0;
    row.count           = 0;
    return row;
  endfunction

  function automatic plan_row_t typed_row(logic [CID_W-1:0] c, logic [VAL_W-1:0] rs,
                                          logic [VAL_W-1:0] rp, int unsigned f,
                                          int unsigned e, logic b);
    plan_row_t row;
    row = req_row(MODE_QUERY, '0, '0, c, rs, rp);
    row.typed           = 1'b1;
    row.hit.first_index = IDX_W'(f);
    row.hit.end_index   = IDX_W'(e);
    row.hit.bad_chrom   = b;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(int unsigned total, int unsigned count);
    plan_row_t row;
    row = req_row(MODE_UNUSED, '0, '0, '0, '0, '0);
    row.kind  = ROW_CFG;
    row.total = total;
    row.count = count;
    return row;
  endfunction

  // One layout of sorted slices, loaded and then queried.
  task automatic run_phase();
    int unsigned nseq;
    int unsigned span;
    int unsigned base;
    int unsigned total;
    int unsigned cum;
    int unsigned scale;
    int unsigned nq;
    int unsigned tries;
    int unsigned sel;
    int unsigned sizes[$];
    longint unsigned v;
    bit         shuffled;
    bit         ok;
    site_req_t  r;
    range_hit_t h;

    stall_pct = calm ? 0 : $urandom_range(0, 3) * 20;
    gap_pct   = calm ? 0 : $urandom_range(0, 3) * 15;
    phase_sites.delete();

    nseq = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    span = 0;
    for (int c = 0; c < nseq; c++) begin
      sizes.insert(sizes.size(), ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12));
      span += sizes[c];
    end
    sel = $urandom_range(0, 5);
    if (sel == 0) base = 0;
    else if (sel == 1) base = MAX_POSITIONS - span;
    else base = $urandom_range(0, MAX_POSITIONS - 1 - span);

    // mostly the layout end; sometimes short, empty or past the loaded area
    sel = $urandom_range(0, 11);
    if (sel == 0) total = 0;
    else if (sel == 1) total = MAX_POSITIONS;
    else if (sel <= 3) total = base + span - $urandom_range(0, span);
    else total = base + span;
    program_regs(total, nseq);

    cum = base;
    for (int c = 0; c < nseq; c++) begin
      r = scrambled_req();
      r.mode  = MODE_LOAD_START;
      r.addr  = ADDR_W'(c);
      r.value = (VAL_W'($urandom()) & 32'hFFE0_0000) | VAL_W'(cum);
      send_req(r);
      track_request(r);
      cum += sizes[c];
    end

    case ($urandom_range(0, 3))
      0: scale = 3;
      1: scale = 1000;
      2: scale = 1 << 24;
      default: scale = 1 << 28;
    endcase
    shuffled = ($urandom_range(0, 7) == 0);
    v = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 32'h7FFF_FFFF);
    for (int a = 0; a < span; a++) begin
      v = v + $urandom_range(0, scale);
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      r = scrambled_req();
      r.mode  = MODE_LOAD_POS;
      r.addr  = ADDR_W'(base + a);
      r.value = shuffled ? $urandom() : v[31:0];
      send_req(r);
      track_request(r);
      phase_sites.insert(phase_sites.size(), r.value);
    end

    nq = $urandom_range(15, 35);
    repeat (nq) begin
      if ($urandom_range(0, 7) == 0) begin
        r = scrambled_req();
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
          r.mode = MODE_UNUSED;
        end else if (sel == 1) begin
          r.mode = MODE_LOAD_START;
        end else begin
          r.mode = MODE_LOAD_POS;
          if (span != 0 && $urandom_range(0, 2) == 0)
            r.addr = ADDR_W'(base + $urandom_range(0, span - 1));
        end
        send_req(r);
        track_request(r);
      end else begin
        ok    = 1'b0;
        tries = 0;
        while (!ok && tries < 40) begin
          r = scrambled_req();
          r.mode = MODE_QUERY;
          if (nseq != 0 && $urandom_range(0, 4) != 0)
            r.cid = CID_W'($urandom_range(0, nseq - 1));
          r.rstart = pick_key();
          sel = $urandom_range(0, 9);
          if (sel < 4) r.rstop = pick_key();
          else if (sel < 7) r.rstop = r.rstart + $urandom_range(0, 50);
          else if (sel < 9) r.rstop = r.rstart - $urandom_range(1, 50);
          else r.rstop = $urandom();
          ok = query_result(r.cid, r.rstart, r.rstop, h);
          tries++;
        end
        if (ok) begin
          send_req(r);
          track_request(r);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    range_hit_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (awaited.size() == 0) begin
        $display("%0t: result with no query pending: first %0d end %0d bad %0b",
                 $time, first_index, end_index, bad_chrom);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        if (first_index !== want.first_index) begin
          $display("%0t: first_index expected %0d got %0d", $time, want.first_index, first_index);
          mismatches++;
        end
        if (end_index !== want.end_index) begin
          $display("%0t: end_index expected %0d got %0d", $time, want.end_index, end_index);
          mismatches++;
        end
        if (bad_chrom !== want.bad_chrom) begin
          $display("%0t: bad_chrom expected %0b got %0b", $time, want.bad_chrom, bad_chrom);
          mismatches++;
        end
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      hold_left = $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    plan_row_t   plan[$];
    int unsigned rand_start;

    // sequence id checks before anything is loaded
    plan.insert(plan.size(), typed_row(0, 0, 0, 0, 0, 1'b1));
    plan.insert(plan.size(), typed_row('1, '1, '0, 0, 0, 1'b1));
    // two short slices: [0,2) and [2,4)
    plan.insert(plan.size(), cfg_row(4, 2));
    plan.insert(plan.size(), req_row(MODE_LOAD_START, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), req_row(MODE_LOAD_START, 1, 2, '1, '1, '1));
    plan.insert(plan.size(), req_row(MODE_LOAD_POS, 0, 10, 0, 0, 0));
    plan.insert(plan.size(), req_row(MODE_LOAD_POS, 1, 20, 0, 0, 0));
    plan.insert(plan.size(), req_row(MODE_LOAD_POS, 2, 5, 0, 0, 0));
    plan.insert(plan.size(), req_row(MODE_LOAD_POS, 3, '1, 0, 0, 0));
    plan.insert(plan.size(), typed_row(0, 0, '1, 0, 2, 1'b0));
    // stop below start
    plan.insert(plan.size(), req_row(MODE_QUERY, 0, 0, 0, 15, 12));
    plan.insert(plan.size(), req_row(MODE_QUERY, 0, 0, 1, '1, '1));
    plan.insert(plan.size(), typed_row(2, 7, 9, 0, 0, 1'b1));
    plan.insert(plan.size(), req_row(MODE_UNUSED, '1, '1, '1, '1, '1));
    // start load past the table is dropped; slice 0 must be unchanged
    plan.insert(plan.size(), req_row(MODE_LOAD_START, '1, 0, 0, 0, 0));
    plan.insert(plan.size(), req_row(MODE_QUERY, 0, 0, 0, 11, 21));
    // start beyond the table clamps to an empty slice at the top
    plan.insert(plan.size(), req_row(MODE_LOAD_START, 1, '1, 0, 0, 0));
    plan.insert(plan.size(), typed_row(1, 0, 0, MAX_POSITIONS, MAX_POSITIONS, 1'b0));
    // last sequence of a full table, slice at the very top
    plan.insert(plan.size(), cfg_row(MAX_POSITIONS, MAX_CHROMS));
    plan.insert(plan.size(),
                req_row(MODE_LOAD_START, MAX_CHROMS - 1, MAX_POSITIONS - 4, 0, 0, 0));
    plan.insert(plan.size(), req_row(MODE_LOAD_POS, MAX_POSITIONS - 4, 0, 0, 0, 0));
    plan.insert(plan.size(), req_row(MODE_LOAD_POS, MAX_POSITIONS - 3, 100, 0, 0, 0));
    plan.insert(plan.size(),
                req_row(MODE_LOAD_POS, MAX_POSITIONS - 2, 32'h8000_0000, 0, 0, 0));
    plan.insert(plan.size(), req_row(MODE_LOAD_POS, '1, '1, 0, 0, 0));
    plan.insert(plan.size(),
                typed_row('1, 0, 1, MAX_POSITIONS - 4, MAX_POSITIONS - 3, 1'b0));
    plan.insert(plan.size(), req_row(MODE_QUERY, 0, 0, '1, '1, '1));
    plan.insert(plan.size(), req_row(MODE_QUERY, 0, 0, '1, 32'h8000_0001, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        program_regs(plan[i].total, plan[i].count);
      end else begin
        send_req(plan[i].req);
        if (plan[i].typed) awaited.insert(awaited.size(), plan[i].hit);
        else track_request(plan[i].req);
      end
    end

    rand_start = reqs_sent;
    while (reqs_sent - rand_start < RAND_ITEMS) begin
      if (reqs_sent - rand_start >= CALM_AFTER) calm = 1'b1;
      run_phase();
    end

    stall_pct = 0;
    settle();
    if (mismatches == 0) begin
      $display("sorted_table_range_to_index_search: match");
    end else begin
      $display("sorted_table_range_to_index_search: mismatch");
    end
    $finish;
  end

endmodule
